>>> sv/rau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rau_pkg;
  localparam int unsigned WORD_WIDTH = 32;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_EQ  = 3'd4;
  localparam logic [2:0] OP_LT  = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;
  localparam logic [1:0] ST_OVF  = 2'd3;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] a_num;
    logic [31:0] a_den;
    logic [31:0] b_num;
    logic [31:0] b_den;
  } req_t;

  typedef struct packed {
    logic [31:0] res_num;
    logic [30:0] res_den;
    logic        cmp_true;
    logic [1:0]  status;
  } rsp_t;
endpackage
`default_nettype wire

>>> sv/rau_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface rau_req_if;
  logic          valid;
  logic          ready;
  rau_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rau_rsp_if;
  logic          valid;
  logic          ready;
  rau_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/rau_divmod.sv
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module rau_divmod #(
  parameter int unsigned W = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              done,
  output logic [W-1:0]      quot,
  output logic [W-1:0]      rem
);
  localparam int unsigned CW = $clog2(W + 1);
  logic [W-1:0]  q_r, q_nxt;
  logic [W:0]    r_r, r_nxt;
  logic [W-1:0]  d_r, d_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic [W:0]    trial, diff;

  always_comb begin
    q_nxt = q_r; r_nxt = r_r; d_nxt = d_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {r_r[W-1:0], q_r[W-1]};
    diff  = trial - {1'b0, d_r};
    if (start) begin
      q_nxt = dividend; r_nxt = '0; d_nxt = divisor;
      cnt_nxt = CW'(W); busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[W]) begin
        r_nxt = diff;
        q_nxt = {q_r[W-2:0], 1'b1};
      end else begin
        r_nxt = trial;
        q_nxt = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt; r_r <= r_nxt; d_r <= d_nxt; cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = r_r[W-1:0];
endmodule
`default_nettype wire

>>> sv/rational_arith_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Rational arithmetic unit: add, subtract, multiply, divide, equal and
// less-than on two fractions, result reduced by Euclid's gcd.
// Input channel in_*: one request (op code and two fractions) per transfer.
// in_ready is high only while the unit is idle and its output register is
// empty; a request is taken, worked on and its result transferred before
// the next one is accepted, at the soonest in the cycle after the result transfer.
// Result channel out_*: one result per request, held in an output register
// until out_ready takes it; while the receiver stalls the unit holds the
// result and accepts nothing.
// A zero denominator or a divide by zero is flagged in state S_M1, right
// after the request is registered; compares pass S_M1 to S_M3, S_SUM and
// S_OUT. Arithmetic results pass through the shared 64-bit restoring
// divider: each gcd step is one division (issued in S_GCD, awaited in S_GW),
// and the numerator and denominator are then divided by the gcd (S_DN and
// S_DNW, then S_DD and S_DDW). The divider's one bit a cycle sets the
// rate.
// Reset (synchronous, rst_n low) returns the sequencer to idle and drops
// any result not yet transferred.
module rational_arith_unit #(
  parameter int unsigned WORD_WIDTH = rau_pkg::WORD_WIDTH
) (
  input wire logic clk,
  input wire logic rst_n,
  rau_req_if.sink  in_ch,
  rau_rsp_if.source out_ch
);
  localparam int unsigned W2 = 2 * WORD_WIDTH;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_M1   = 4'd1;
  localparam logic [3:0] S_M2   = 4'd2;
  localparam logic [3:0] S_M3   = 4'd3;
  localparam logic [3:0] S_SUM  = 4'd4;
  localparam logic [3:0] S_GCD  = 4'd5;
  localparam logic [3:0] S_GW   = 4'd6;
  localparam logic [3:0] S_DN   = 4'd7;
  localparam logic [3:0] S_DNW  = 4'd8;
  localparam logic [3:0] S_DD   = 4'd9;
  localparam logic [3:0] S_DDW  = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  logic [3:0] st_r, st_nxt;
  logic [2:0] op_r;
  logic [WORD_WIDTH-1:0] an_r, ad_r, bn_r, bd_r;
  logic ans_r, bns_r;
  logic [W2-1:0] p_r, q_r, m_r, x_r, y_r, g_r, num_r;
  logic pn_r, qn_r, rn_r;
  logic [1:0] mcnt_r;
  rau_pkg::rsp_t rsp_r;
  logic ovalid_r;

  function automatic logic [WORD_WIDTH:0] magw(input logic [31:0] v);
    logic [WORD_WIDTH-1:0] w;
    w = v[WORD_WIDTH-1:0];
    magw = w[WORD_WIDTH-1] ? ({1'b0, ~w} + (WORD_WIDTH+1)'(1)) : {1'b0, w};
  endfunction

  // Multiplier operand selection (one product per cycle).
  logic [WORD_WIDTH:0] an_m, ad_m, bn_m, bd_m, ma, mb;
  logic [W2+1:0] prod_full;
  logic [W2-1:0] prod;
  assign an_m = magw(32'(an_r));
  assign ad_m = magw(32'(ad_r));
  assign bn_m = magw(32'(bn_r));
  assign bd_m = magw(32'(bd_r));
  always_comb begin
    case (mcnt_r)
      2'd0: begin ma = an_m; mb = (op_r == rau_pkg::OP_MUL) ? bn_m : bd_m; end
      2'd1: begin ma = bn_m; mb = ad_m; end
      2'd2: begin
        ma = (op_r == rau_pkg::OP_DIV) ? bn_m : ad_m;
        mb = (op_r == rau_pkg::OP_DIV) ? ad_m : bd_m;
      end
      default: begin ma = '0; mb = '0; end
    endcase
  end
  assign prod_full = ma * mb;
  assign prod = prod_full[W2-1:0];

  logic dv_start, dv_done;
  logic [W2-1:0] dv_a, dv_b, dv_q, dv_r;
  rau_divmod #(.W(W2)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(dv_a), .divisor(dv_b),
    .done(dv_done), .quot(dv_q), .rem(dv_r)
  );

  logic in_fire, out_fire;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = ovalid_r && out_ch.ready;
  assign in_ch.ready = (st_r == S_IDLE) && !ovalid_r;
  assign out_ch.valid = ovalid_r;
  assign out_ch.data  = rsp_r;

  logic qneg_eff, an_s, ad_s, bn_s, bd_s;
  logic [W2-1:0] lim;
  assign an_s = an_r[WORD_WIDTH-1];
  assign ad_s = ad_r[WORD_WIDTH-1];
  assign bn_s = bn_r[WORD_WIDTH-1];
  assign bd_s = bd_r[WORD_WIDTH-1];
  assign lim = (W2'(1) << (WORD_WIDTH - 1)) - W2'(1);

  logic zden, divz, sm_lt;
  assign zden = (ad_r == '0) || (bd_r == '0);
  assign divz = (op_r == rau_pkg::OP_DIV) && (bn_r == '0);

  always_comb begin
    st_nxt = st_r;
    dv_start = 1'b0;
    dv_a = x_r;
    dv_b = y_r;
    case (st_r)
      S_IDLE:  if (in_fire) st_nxt = S_M1;
      S_M1:    st_nxt = (zden || divz) ? S_IDLE : S_M2;
      S_M2:    st_nxt = S_M3;
      S_M3:    st_nxt = S_SUM;
      S_SUM:   st_nxt = (op_r >= rau_pkg::OP_EQ) ? S_OUT : S_GCD;
      S_GCD: begin
        if (y_r == '0) st_nxt = S_DN;
        else begin dv_start = 1'b1; st_nxt = S_GW; end
      end
      S_GW:    if (dv_done) st_nxt = S_GCD;
      S_DN: begin dv_start = 1'b1; dv_a = num_r; dv_b = g_r; st_nxt = S_DNW; end
      S_DNW:   if (dv_done) st_nxt = S_DD;
      S_DD: begin dv_start = 1'b1; dv_a = m_r; dv_b = g_r; st_nxt = S_DDW; end
      S_DDW:   if (dv_done) st_nxt = S_OUT;
      S_OUT:   st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r <= in_ch.data.req_type;
      an_r <= in_ch.data.a_num[WORD_WIDTH-1:0];
      ad_r <= in_ch.data.a_den[WORD_WIDTH-1:0];
      bn_r <= in_ch.data.b_num[WORD_WIDTH-1:0];
      bd_r <= in_ch.data.b_den[WORD_WIDTH-1:0];
      mcnt_r <= 2'd0;
    end
    if (st_r == S_M1 || st_r == S_M2 || st_r == S_M3) mcnt_r <= mcnt_r + 2'd1;
    if (st_r == S_M1) begin
      p_r  <= prod;
      ans_r <= (an_m != '0) && (an_s != ad_s);
      pn_r <= (an_m != '0) && (an_s != ad_s);
    end
    if (st_r == S_M2) begin
      q_r  <= prod;
      bns_r <= (bn_m != '0) && (bn_s != bd_s);
      qn_r <= (bn_m != '0) && (bn_s != bd_s);
    end
    if (st_r == S_M3) m_r <= prod;
    if (st_r == S_SUM) begin
      // Numerator and sign from cross products; denominator is m_r.
      if (op_r == rau_pkg::OP_MUL || op_r == rau_pkg::OP_DIV) begin
        num_r <= p_r;
        rn_r  <= (p_r != '0) && (ans_r != bns_r);
      end else if (pn_r == qneg_eff) begin
        num_r <= p_r + q_r;
        rn_r  <= pn_r && ((p_r + q_r) != '0);
      end else if (p_r >= q_r) begin
        num_r <= p_r - q_r;
        rn_r  <= pn_r && (p_r != q_r);
      end else begin
        num_r <= q_r - p_r;
        rn_r  <= qneg_eff;
      end
      x_r <= (op_r == rau_pkg::OP_MUL || op_r == rau_pkg::OP_DIV) ? p_r :
             ((pn_r == qneg_eff) ? p_r + q_r : ((p_r >= q_r) ? p_r - q_r : q_r - p_r));
      y_r <= m_r;
    end
    if (st_r == S_GW && dv_done) begin
      x_r <= y_r;
      y_r <= dv_r;
    end
    if (st_r == S_GCD && y_r == '0) g_r <= x_r;
    if (st_r == S_DNW && dv_done) num_r <= dv_q;
    if (st_r == S_DDW && dv_done) m_r <= dv_q;
  end

  assign qneg_eff = (op_r == rau_pkg::OP_SUB || op_r == rau_pkg::OP_LT) ?
                    ((q_r != '0) && !qn_r) : qn_r;

  // p - q negative
  assign sm_lt = (pn_r == qneg_eff) ? (pn_r && ((p_r + q_r) != '0))
               : ((p_r >= q_r) ? (pn_r && (p_r != q_r)) : qneg_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_M1 && zden) begin
        ovalid_r <= 1'b1;
        rsp_r <= '{res_num: '0, res_den: '0, cmp_true: 1'b0, status: rau_pkg::ST_ZDEN};
      end else if (st_r == S_M1 && divz) begin
        ovalid_r <= 1'b1;
        rsp_r <= '{res_num: '0, res_den: '0, cmp_true: 1'b0, status: rau_pkg::ST_DIVZ};
      end else if (st_r == S_OUT) begin
        ovalid_r <= 1'b1;
        if (op_r >= rau_pkg::OP_EQ) begin
          rsp_r.res_num <= '0;
          rsp_r.res_den <= 31'd1;
          rsp_r.status  <= rau_pkg::ST_OK;
          rsp_r.cmp_true <=
            (op_r == rau_pkg::OP_EQ) ? ((p_r == q_r) && (pn_r == qn_r))
            : (op_r == rau_pkg::OP_LT) ? sm_lt : 1'b0;
        end else if (m_r > lim || num_r > lim + W2'(rn_r)) begin
          rsp_r <= '{res_num: '0, res_den: '0, cmp_true: 1'b0, status: rau_pkg::ST_OVF};
        end else begin
          rsp_r.res_num <= rn_r ? 32'(64'd0 - 64'(num_r)) : 32'(num_r);
          rsp_r.res_den <= 31'(m_r);
          rsp_r.cmp_true <= 1'b0;
          rsp_r.status <= rau_pkg::ST_OK;
        end
      end else if (out_fire) begin
        ovalid_r <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire
